// ----- design/ajb_pkg.sv -----
// Shared types and constants for the audio jitter buffer.
package ajb_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_END    = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    localparam logic [7:0] FLAG_SYNC_MASTER = 8'd1;
    localparam logic [7:0] FLAG_SYNC_CLIENT = 8'd2;
    localparam logic [15:0] CAPACITY_RESET  = 16'd20480;
    localparam logic [13:0] OFFSET_STEP     = 14'd8;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PCT   = 7'b0000010,
        ST_THR   = 7'b0000100,
        ST_MOD   = 7'b0001000,
        ST_MEM   = 7'b0010000,
        ST_RDW   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    // Status from the shared divider.
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [16:0] remainder;
    } t_div_rsp;

endpackage

// ----- design/ajb_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
module ajb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ajb_pkg::t_div_req i_req,
    output ajb_pkg::t_div_rsp o_rsp
);

    logic [31:0] r_quo;
    logic [16:0] r_rem;
    logic [16:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_trial;
    logic [17:0] w_diff;

    // Shift in the next dividend bit and try a subtract.
    assign w_trial = {r_rem, r_quo[31]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (w_diff[17]) begin
                    r_rem <= w_trial[16:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end else begin
                    r_rem <= w_diff[16:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- design/audio_jitter_buffer_drift_control.sv -----
// Top level of the stereo audio jitter buffer with drift control.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  item in  | i_valid/o_ready, i_kind .. i_right_word | in
//  result   | o_valid/i_ready, o_out_left .. o_fill_level | out
//  config   | i_cfg_we, i_cfg_wdata (capacity)      | in
//
// From the input transfer to o_valid: a header waits on one pass of the shared
// divider for the fill percentage; a sample while draining waits on one divider
// pass for the offset remainder, unless the percentage is 100; other samples,
// reads and packet ends do not wait on the divider.
// The frame store is one synchronous memory with a registered read port.
// Reset is synchronous; the frame store is not cleared. o_ready stays low from
// the input transfer until the result transfers, so a stalled result stalls
// the input and no new item is taken before the last result has transferred.
module audio_jitter_buffer_drift_control #(
    parameter int FIFO_DEPTH = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_packet_index,
    input  logic [7:0]  i_packet_flags,
    input  logic [31:0] i_left_word,
    input  logic [31:0] i_right_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_left,
    output logic [31:0] o_out_right,
    output logic        o_silent,
    output logic [31:0] o_lost_total,
    output logic [31:0] o_skipped_total,
    output logic        o_sync_event,
    output logic        o_sync_master,
    output logic [16:0] o_fill_level,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam logic [16:0] DEPTH17 = 17'(FIFO_DEPTH);

    ajb_pkg::t_state r_state;
    ajb_pkg::t_kind  r_kind;
    logic [31:0] r_pidx;
    logic [7:0]  r_flags;
    logic [63:0] r_wdata;
    logic [15:0] r_cap_reg;
    logic [16:0] w_cap;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_wr_ptr;
    logic [CW-1:0] r_count;
    logic [31:0] r_expected;
    logic        r_awaiting;
    logic        r_draining;
    logic [6:0]  r_percent;
    logic [13:0] r_offset;
    logic [31:0] r_lost;
    logic [31:0] r_skip;
    logic        r_silence;
    logic        r_end_discard;
    logic [31:0] r_n100;
    logic [63:0] r_rdata;
    logic        r_pop;
    logic        r_drop;
    logic        r_sync_ev;
    logic        r_sync_m;
    logic [63:0] r_mem [FIFO_DEPTH];

    ajb_pkg::t_div_req w_req;
    ajb_pkg::t_div_rsp w_rsp;
    logic [31:0] w_gap;
    logic [32:0] w_lost_sum;
    logic [31:0] w_skip_inc;
    logic        w_accept;
    logic [6:0]  w_div7;
    logic [31:0] w_cap32;
    logic [31:0] w_c70;
    logic [31:0] w_c30;
    logic [31:0] w_c60;
    logic [16:0] w_count17;
    logic        w_full;

    assign o_ready  = (r_state == ajb_pkg::ST_IDLE) && !o_valid;
    assign w_accept = i_valid && o_ready;

    // Effective capacity, clamped to 1..FIFO_DEPTH.
    always_comb begin
        if (r_cap_reg == 16'd0) begin
            w_cap = 17'd1;
        end else if ({1'b0, r_cap_reg} > DEPTH17) begin
            w_cap = DEPTH17;
        end else begin
            w_cap = {1'b0, r_cap_reg};
        end
    end

    assign w_count17 = 17'(r_count);
    assign w_full    = (w_count17 >= w_cap);

    assign w_cap32 = {15'd0, w_cap};
    assign w_c70 = (w_cap32 << 6) + (w_cap32 << 2) + (w_cap32 << 1);
    assign w_c30 = (w_cap32 << 5) - (w_cap32 << 1);
    assign w_c60 = (w_cap32 << 6) - (w_cap32 << 2);
    assign w_div7 = 7'd100 - r_percent;
    assign w_gap = (r_pidx > r_expected) ? r_pidx - r_expected : r_expected - r_pidx;
    assign w_lost_sum = {1'b0, r_lost} + {1'b0, w_gap};
    assign w_skip_inc = (r_skip == 32'hFFFF_FFFF) ? r_skip : r_skip + 32'd1;

    // Divider start: fill percentage for headers, offset remainder for samples.
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_n100;
        w_req.divisor  = w_cap;
        if (r_state == ajb_pkg::ST_PCT) begin
            w_req.start = 1'b1;
        end else if (r_state == ajb_pkg::ST_THR && r_kind == ajb_pkg::KIND_SAMPLE) begin
            w_req.start    = 1'b1;
            w_req.dividend = {18'd0, r_offset};
            w_req.divisor  = {10'd0, w_div7};
        end
    end

    ajb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Frame store: one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == ajb_pkg::ST_MEM && r_kind == ajb_pkg::KIND_SAMPLE && !r_drop
            && !w_full) begin
            r_mem[r_wr_ptr] <= r_wdata;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    // Sequencer and state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ajb_pkg::ST_IDLE;
            r_cap_reg     <= ajb_pkg::CAPACITY_RESET;
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_count       <= '0;
            r_expected    <= '0;
            r_awaiting    <= 1'b1;
            r_draining    <= 1'b0;
            r_percent     <= '0;
            r_offset      <= ajb_pkg::OFFSET_STEP;
            r_lost        <= '0;
            r_skip        <= '0;
            r_silence     <= 1'b1;
            r_end_discard <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap_reg <= i_cfg_wdata;
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ajb_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_kind  <= ajb_pkg::t_kind'(i_kind);
                        r_pidx  <= i_packet_index;
                        r_flags <= i_packet_flags;
                        r_wdata <= {i_right_word, i_left_word};
                        r_n100  <= 32'(r_count) * 32'd100;
                        r_pop   <= 1'b0;
                        r_drop  <= 1'b0;
                        r_sync_ev <= 1'b0;
                        r_sync_m  <= 1'b0;
                        case (ajb_pkg::t_kind'(i_kind))
                            ajb_pkg::KIND_HEADER: r_state <= ajb_pkg::ST_PCT;
                            ajb_pkg::KIND_SAMPLE: r_state <= ajb_pkg::ST_THR;
                            default:              r_state <= ajb_pkg::ST_MEM;
                        endcase
                    end
                end
                ajb_pkg::ST_PCT: begin
                    // Sequence tracking, sync flags and drain and end-discard thresholds while the divider runs.
                    if (r_awaiting) begin
                        r_awaiting <= 1'b0;
                    end else if (r_pidx != r_expected) begin
                        r_lost <= w_lost_sum[32] ? 32'hFFFF_FFFF : w_lost_sum[31:0];
                    end
                    r_expected <= r_pidx + 32'd1;
                    r_sync_ev <= (r_flags == ajb_pkg::FLAG_SYNC_MASTER) ||
                                 (r_flags == ajb_pkg::FLAG_SYNC_CLIENT);
                    r_sync_m  <= (r_flags == ajb_pkg::FLAG_SYNC_MASTER);
                    if (!r_draining && r_n100 > w_c70) begin
                        r_draining <= 1'b1;
                    end else if (r_draining && r_n100 < w_c30) begin
                        r_draining <= 1'b0;
                    end
                    r_end_discard <= (r_n100 > w_c60);
                    r_offset <= ajb_pkg::OFFSET_STEP;
                    r_state  <= ajb_pkg::ST_MOD;
                end
                ajb_pkg::ST_THR: begin
                    // Sample: decide the drop, waiting on the remainder if draining below 100 percent.
                    if (!r_draining) begin
                        r_state <= ajb_pkg::ST_MEM;
                    end else if (w_div7 == 7'd0) begin
                        r_drop  <= 1'b1;
                        r_state <= ajb_pkg::ST_MEM;
                    end else begin
                        r_state <= ajb_pkg::ST_MOD;
                    end
                end
                ajb_pkg::ST_MOD: begin
                    if (w_rsp.done) begin
                        if (r_kind == ajb_pkg::KIND_HEADER) begin
                            r_percent <= (w_rsp.quotient > 32'd100) ? 7'd100
                                                                    : w_rsp.quotient[6:0];
                            r_state   <= ajb_pkg::ST_OUT;
                        end else begin
                            r_drop  <= (w_rsp.remainder == 17'd0);
                            r_state <= ajb_pkg::ST_MEM;
                        end
                    end
                end
                ajb_pkg::ST_MEM: begin
                    case (r_kind)
                        ajb_pkg::KIND_SAMPLE: begin
                            if (r_drop || w_full) begin
                                r_drop <= 1'b1;
                                r_skip <= w_skip_inc;
                            end else begin
                                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
                                r_count  <= r_count + 1'b1;
                            end
                            r_offset <= r_offset + ajb_pkg::OFFSET_STEP;
                            r_state  <= ajb_pkg::ST_OUT;
                        end
                        ajb_pkg::KIND_END: begin
                            if (r_end_discard) begin
                                r_skip <= w_skip_inc;
                                if (r_count != '0) begin
                                    r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
                                    r_count  <= r_count - 1'b1;
                                end
                            end
                            r_state <= ajb_pkg::ST_OUT;
                        end
                        ajb_pkg::KIND_READ: begin
                            if (r_count == '0) begin
                                r_silence <= 1'b1;
                                r_state   <= ajb_pkg::ST_OUT;
                            end else begin
                                r_pop   <= 1'b1;
                                r_state <= ajb_pkg::ST_RDW;
                            end
                        end
                        default: r_state <= ajb_pkg::ST_OUT;
                    endcase
                end
                ajb_pkg::ST_RDW: begin
                    // Read data for the old pointer is registered now; advance.
                    r_rd_ptr  <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
                    r_count   <= r_count - 1'b1;
                    r_silence <= 1'b0;
                    r_wdata   <= r_rdata;
                    r_state   <= ajb_pkg::ST_OUT;
                end
                ajb_pkg::ST_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= ajb_pkg::ST_IDLE;
                end
                default: r_state <= ajb_pkg::ST_IDLE;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == ajb_pkg::ST_OUT) begin
            o_out_left      <= r_pop ? r_wdata[31:0]  : 32'd0;
            o_out_right     <= r_pop ? r_wdata[63:32] : 32'd0;
            o_silent        <= r_silence;
            o_lost_total    <= r_lost;
            o_skipped_total <= r_skip;
            o_sync_event    <= r_sync_ev;
            o_sync_master   <= r_sync_m;
            o_fill_level    <= 17'(r_count);
        end
    end

    // The count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count17 <= DEPTH17)
        else $error("fill count above depth");
    // No item is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("accept while result pending");
    // Sync master implies a sync event.
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sync_master) |-> o_sync_event)
        else $error("master without event");

endmodule

// ----- sim/testbench.sv -----
// Testbench for the audio jitter buffer: directed and random packet traffic checked against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32768;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        silent;
        logic [31:0] lost;
        logic [31:0] skipped;
        logic        sync_event;
        logic        sync_master;
        logic [16:0] fill;
    } t_frame_result;

    // Predict one result per transfer and hold the predictions in order.
    class t_audio_scoreboard;
        bit [63:0]     frames[int];
        int unsigned   rd_ptr, wr_ptr, count;
        bit [31:0]     next_seq;
        bit            first_pending, drain_on, discard_at_end, silence;
        int unsigned   pct;
        bit [13:0]     offset;
        bit [31:0]     lost, skipped;
        bit [15:0]     capacity;
        t_frame_result pending_results[$];
        int            errors, checked;

        function void reset_state();
            rd_ptr = 0; wr_ptr = 0; count = 0; next_seq = 0;
            first_pending = 1; drain_on = 0; discard_at_end = 0; silence = 1;
            pct = 0; offset = 14'd8; lost = 0; skipped = 0;
            capacity = ajb_pkg::CAPACITY_RESET;
        endfunction

        function void set_capacity(bit [15:0] value);
            capacity = value;
        endfunction

        function bit [31:0] sat_inc(bit [31:0] a, bit [31:0] b);
            bit [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function bit [63:0] pop();
            bit [63:0] f;
            f = frames[rd_ptr];
            rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
            count--;
            return f;
        endfunction

        function void note_input(ajb_pkg::t_kind kind, bit [31:0] pidx, bit [7:0] flags,
                                 bit [31:0] lw, bit [31:0] rw);
            t_frame_result r;
            longint unsigned cap, n100, p;
            int unsigned divisor;
            bit drop;
            bit [63:0] f;
            cap = (capacity == 0) ? 1 : capacity;
            if (cap > DEPTH) cap = DEPTH;
            r = '0;
            case (kind)
                ajb_pkg::KIND_HEADER: begin
                    n100 = longint'(count) * 100;
                    if (first_pending) begin
                        next_seq = pidx;
                        first_pending = 0;
                    end else if (pidx != next_seq) begin
                        lost = sat_inc(lost, (pidx > next_seq) ? pidx - next_seq
                                                               : next_seq - pidx);
                        next_seq = pidx;
                    end
                    next_seq = next_seq + 1;
                    if (flags == ajb_pkg::FLAG_SYNC_MASTER ||
                        flags == ajb_pkg::FLAG_SYNC_CLIENT) begin
                        r.sync_event = 1;
                        r.sync_master = (flags == ajb_pkg::FLAG_SYNC_MASTER);
                    end
                    p = n100 / cap;
                    pct = (p > 100) ? 100 : int'(p);
                    if (!drain_on && n100 > 70 * cap) drain_on = 1;
                    else if (drain_on && n100 < 30 * cap) drain_on = 0;
                    discard_at_end = (n100 > 60 * cap);
                    offset = 14'd8;
                end
                ajb_pkg::KIND_SAMPLE: begin
                    drop = 0;
                    if (drain_on) begin
                        divisor = 100 - pct;
                        if (divisor == 0 || (offset % divisor) == 0) drop = 1;
                    end
                    if (drop || count >= cap) begin
                        skipped = sat_inc(skipped, 32'd1);
                    end else begin
                        frames[wr_ptr] = {rw, lw};
                        wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
                        count++;
                    end
                    offset = offset + 14'd8;
                end
                ajb_pkg::KIND_END: begin
                    if (discard_at_end) begin
                        if (count > 0) f = pop();
                        skipped = sat_inc(skipped, 32'd1);
                    end
                end
                default: begin
                    if (count == 0) begin
                        silence = 1;
                    end else begin
                        f = pop();
                        r.left = f[31:0];
                        r.right = f[63:32];
                        silence = 0;
                    end
                end
            endcase
            r.silent = silence;
            r.lost = lost;
            r.skipped = skipped;
            r.fill = 17'(count[15:0]);
            pending_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t mismatch %s: expected %h actual %h", $realtime, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result act);
            t_frame_result e;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $realtime, act);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            compare("out_left", e.left, act.left);
            compare("out_right", e.right, act.right);
            compare("silent", e.silent, act.silent);
            compare("lost_total", e.lost, act.lost);
            compare("skipped_total", e.skipped, act.skipped);
            compare("sync_event", e.sync_event, act.sync_event);
            compare("sync_master", e.sync_master, act.sync_master);
            compare("fill_level", e.fill, act.fill);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_packet_index = '0;
    logic [7:0]  i_packet_flags = '0;
    logic [31:0] i_left_word = '0;
    logic [31:0] i_right_word = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_out_left, o_out_right, o_lost_total, o_skipped_total;
    logic        o_silent, o_sync_event, o_sync_master;
    logic [16:0] o_fill_level;
    logic        i_cfg_we = 0;
    logic [15:0] i_cfg_wdata = '0;

    t_audio_scoreboard sb = new();
    bit          calm = 0;
    int          items_sent = 0;
    int          phases_run = 0;
    bit [31:0]   seq_guess = 0;

    audio_jitter_buffer_drift_control dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_packet_index(i_packet_index),
        .i_packet_flags(i_packet_flags),
        .i_left_word(i_left_word), .i_right_word(i_right_word),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_left(o_out_left), .o_out_right(o_out_right),
        .o_silent(o_silent), .o_lost_total(o_lost_total),
        .o_skipped_total(o_skipped_total), .o_sync_event(o_sync_event),
        .o_sync_master(o_sync_master), .o_fill_level(o_fill_level),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Take results with random stalls and check each transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result({o_out_left, o_out_right, o_silent, o_lost_total,
                                 o_skipped_total, o_sync_event, o_sync_master,
                                 o_fill_level});
            i_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // Hold one item on the input until it transfers.
    task automatic send_item(ajb_pkg::t_kind kind, bit [31:0] pidx, bit [7:0] flags,
                             bit [31:0] lw, bit [31:0] rw);
        if (!calm && $urandom_range(99) < 13) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_packet_index <= pidx;
        i_packet_flags <= flags;
        i_left_word <= lw;
        i_right_word <= rw;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(kind, pidx, flags, lw, rw);
        items_sent++;
        if (kind == ajb_pkg::KIND_HEADER) seq_guess = pidx + 1;
    endtask

    // Drain all results, let the block settle, then write the capacity.
    task automatic write_capacity(bit [15:0] value);
        i_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_capacity(value);
        phases_run++;
    endtask

    function automatic bit [7:0] pick_flags();
        int r;
        r = $urandom_range(99);
        if (r < 20) return ajb_pkg::FLAG_SYNC_MASTER;
        if (r < 40) return ajb_pkg::FLAG_SYNC_CLIENT;
        return 8'($urandom_range(255));
    endfunction

    // One packet: header, samples with reads mixed in, then usually the packet end.
    task automatic send_packet();
        bit [31:0] pidx;
        int n, r;
        r = $urandom_range(99);
        if (r < 70) pidx = seq_guess;
        else if (r < 90) pidx = seq_guess + $urandom_range(1, 5) - 3;
        else pidx = $urandom;
        send_item(ajb_pkg::KIND_HEADER, pidx, pick_flags(), $urandom, $urandom);
        n = $urandom_range(0, 12);
        repeat (n) begin
            send_item(ajb_pkg::KIND_SAMPLE, $urandom, 8'($urandom), $urandom, $urandom);
            if ($urandom_range(99) < 35)
                send_item(ajb_pkg::KIND_READ, $urandom, 8'($urandom), $urandom, $urandom);
        end
        if ($urandom_range(99) < 90)
            send_item(ajb_pkg::KIND_END, $urandom, 8'($urandom), $urandom, $urandom);
        // occasional burst of reads to pull the fill back down
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 20))
                send_item(ajb_pkg::KIND_READ, $urandom, 8'($urandom), $urandom, $urandom);
    endtask

    initial begin
        bit [15:0] caps[] = '{16'd1, 16'd0, 16'd4, 16'd10, 16'd65535, 16'd16,
                              16'd37, 16'd32768, 16'd100};
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty reads and ends, sequence extremes, sync flags
        send_item(ajb_pkg::KIND_READ, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_END, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'hFFFF_FFFF, ajb_pkg::FLAG_SYNC_MASTER, 0, 0);
        send_item(ajb_pkg::KIND_SAMPLE, 0, 0, 32'hFFFF_FFFF, 32'h0);
        send_item(ajb_pkg::KIND_SAMPLE, 0, 0, 32'h0, 32'hFFFF_FFFF);
        send_item(ajb_pkg::KIND_HEADER, 32'h0, ajb_pkg::FLAG_SYNC_CLIENT, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'd5, 8'd3, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'd2, 8'hFF, 0, 0);
        send_item(ajb_pkg::KIND_READ, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_READ, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_READ, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'hFFFF_FFFF, 8'd0, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'h0, 8'd0, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'hFFFF_FFFF, 8'd0, 0, 0);
        send_item(ajb_pkg::KIND_HEADER, 32'h0, 8'd0, 0, 0);
        send_item(ajb_pkg::KIND_END, 0, 0, 0, 0);

        // directed with capacity one: full drops, percent 100, drain drops
        write_capacity(16'd1);
        send_item(ajb_pkg::KIND_SAMPLE, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(ajb_pkg::KIND_SAMPLE, 0, 0, 32'h1234_5678, 32'h9ABC_DEF0);
        send_item(ajb_pkg::KIND_HEADER, 32'd1, ajb_pkg::FLAG_SYNC_MASTER, 0, 0);
        send_item(ajb_pkg::KIND_SAMPLE, 0, 0, 32'h1, 32'h2);
        send_item(ajb_pkg::KIND_END, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_END, 0, 0, 0, 0);
        send_item(ajb_pkg::KIND_READ, 0, 0, 0, 0);

        // random phases across the capacity settings
        foreach (caps[i]) begin
            if (i > 0) write_capacity(caps[i]);
            while (items_sent < 25 + (i + 1) * 1950 / caps.size()) begin
                calm = (items_sent >= 900 && items_sent < 1150);
                if ($urandom_range(99) < 10)
                    send_item(ajb_pkg::t_kind'($urandom_range(3)), $urandom, pick_flags(),
                              $urandom, $urandom);
                else
                    send_packet();
            end
        end
        calm = 0;
        i_valid <= 0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d items and %0d results over %0d capacity writes",
                 items_sent, sb.checked, phases_run);
        $display("final lost %0d, skipped %0d, mismatches %0d",
                 sb.lost, sb.skipped, sb.errors);
        if (sb.errors == 0)
            $display("audio_jitter_buffer_drift_control regression: pass");
        else
            $display("audio_jitter_buffer_drift_control regression: fail");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #20ms;
        $display("audio_jitter_buffer_drift_control regression: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
design/ajb_pkg.sv
design/ajb_div.sv
design/audio_jitter_buffer_drift_control.sv
sim/testbench.sv
